[src/bsf_pkg.sv]
// ----------------------------------------------------------------------------
// Byte stuffing framer package
// Shared types and constants for the framer's front end, queue and back end.
// ----------------------------------------------------------------------------
package bsf_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FLAG   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 1'b1;

    localparam logic [BYTE_W-1:0] FLAG_RESET   = 8'd36;
    localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd47;

    // Output stream packing widths.
    localparam int OUT_DATA_W = 16;
    localparam int OUT_USER_W = 1;

    // One classified input byte, as handed from the front end to the back end.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              open;
        logic              esc;
        logic              close;
    } bsf_desc_t;

endpackage

[src/byte_stuff_framer_with_parity_core.sv]
// ----------------------------------------------------------------------------
// Byte stuffing framer with parity
// Wraps payload bytes in flag bytes, escapes flag and escape values, and
// reports the XOR parity of each stuffed frame with its closing flag.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat carries
//  s_*       in         payload byte, tlast marks the last byte of a frame
//  m_*       out        stuffed byte, frame parity, closing-flag mark
//  cfg_*     in         register index and value (0 flag, 1 escape)
//
//  The back end sends one output beat per cycle unless stalled, so an input
//  byte gives one to four beats: the data, plus one each for an opening
//  flag, an escape and a closing flag. A byte is registered in the queue
//  and then in the output register. The queue of QUEUE_DEPTH entries lets
//  the input side keep accepting while the output is stalled. After reset
//  the flag is 36 and the escape 47; the configuration port is always ready.
//
module byte_stuff_framer_with_parity_core
    import bsf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,      // [7:0] payload_byte
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,      // [7:0] out_byte, [8] frame_parity
    output logic                  m_tlast,
    output logic [OUT_USER_W-1:0] m_tuser,      // [0] frame_closed
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]            cfg_data
);

    logic [BYTE_W-1:0] flag_reg;
    logic [BYTE_W-1:0] flag_next;
    logic [BYTE_W-1:0] escape_reg;
    logic [BYTE_W-1:0] escape_next;

    logic      q_full;
    logic      push;
    logic      pop;
    logic      head_valid;
    bsf_desc_t wr_desc;
    bsf_desc_t head;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        flag_next   = flag_reg;
        escape_next = escape_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FLAG:   flag_next   = cfg_data;
                CFG_ESCAPE: escape_next = cfg_data;
                default:    flag_next   = flag_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg   <= FLAG_RESET;
            escape_reg <= ESCAPE_RESET;
        end
        else
        begin
            flag_reg   <= flag_next;
            escape_reg <= escape_next;
        end
    end

    bsf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .flag_byte   (flag_reg),
        .escape_byte (escape_reg),
        .q_full      (q_full),
        .push        (push),
        .desc        (wr_desc)
    );

    bsf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_desc  (wr_desc),
        .pop      (pop),
        .rd_desc  (head),
        .rd_valid (head_valid),
        .full     (q_full)
    );

    bsf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .head_valid  (head_valid),
        .pop         (pop),
        .flag_byte   (flag_reg),
        .escape_byte (escape_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule

[src/bsf_front.sv]
// ----------------------------------------------------------------------------
// Byte stuffing framer front end
// Accepts payload beats, tracks frame position and decides which of the
// opening flag, escape and closing flag each byte needs.
// ----------------------------------------------------------------------------
module bsf_front
    import bsf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,
    input  logic              s_tlast,
    input  logic [BYTE_W-1:0] flag_byte,
    input  logic [BYTE_W-1:0] escape_byte,
    input  logic              q_full,
    output logic              push,
    output bsf_desc_t         desc
);

    logic inside_reg;
    logic inside_next;

    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        desc.data  = s_tdata;
        desc.open  = !inside_reg;
        // A byte matching both registers still gets just one escape.
        desc.esc   = (s_tdata == flag_byte) || (s_tdata == escape_byte);
        desc.close = s_tlast;
    end

    always_comb
    begin
        inside_next = inside_reg;
        if (push)
        begin
            inside_next = !s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg <= 1'b0;
        end
        else
        begin
            inside_reg <= inside_next;
        end
    end

endmodule

[src/bsf_queue.sv]
// ----------------------------------------------------------------------------
// Byte stuffing framer queue
// Small first-in first-out store of classified bytes between the two halves.
// ----------------------------------------------------------------------------
module bsf_queue
    import bsf_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  bsf_desc_t wr_desc,
    input  logic      pop,
    output bsf_desc_t rd_desc,
    output logic      rd_valid,
    output logic      full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bsf_desc_t         mem [DEPTH];
    logic [AW-1:0]     wr_ptr_reg;
    logic [AW-1:0]     wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg;
    logic [AW-1:0]     rd_ptr_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_desc  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_desc;
        end
    end

endmodule

[src/bsf_back.sv]
// ----------------------------------------------------------------------------
// Byte stuffing framer back end
// Emits the opening flag, escape, data byte and closing flag of each queued
// byte, one beat per cycle unless stalled, and keeps running frame parity.
// ----------------------------------------------------------------------------
module bsf_back
    import bsf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  bsf_desc_t             head,
    input  logic                  head_valid,
    output logic                  pop,
    input  logic [BYTE_W-1:0]     flag_byte,
    input  logic [BYTE_W-1:0]     escape_byte,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    output logic [OUT_USER_W-1:0] m_tuser
);

    // Bit positions of the pending step mask.
    localparam int STEP_OPEN  = 0;
    localparam int STEP_ESC   = 1;
    localparam int STEP_DATA  = 2;
    localparam int STEP_CLOSE = 3;

    logic              cur_valid_reg;
    logic              cur_valid_next;
    logic [3:0]        rem_reg;
    logic [BYTE_W-1:0] data_reg;
    logic              par_reg;
    logic              par_next;

    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;
    logic [BYTE_W-1:0]     out_byte_reg;
    logic                  out_last_reg;
    logic                  out_closed_reg;
    logic                  out_par_reg;

    logic [3:0]        src_rem;
    logic [BYTE_W-1:0] src_data;
    logic [3:0]        step;
    logic [3:0]        rem_after;
    logic [BYTE_W-1:0] emit_byte;
    logic              out_free;
    logic              fire;
    logic              closing;
    logic              new_par;

    always_comb
    begin
        src_rem  = cur_valid_reg ? rem_reg
                                 : {head.close, 1'b1, head.esc, head.open};
        src_data = cur_valid_reg ? data_reg : head.data;
        out_free = !m_tvalid_reg || m_tready;
        fire     = (cur_valid_reg || head_valid) && out_free;
        pop      = fire && !cur_valid_reg;

        // The lowest pending step goes out first.
        step      = '0;
        emit_byte = flag_byte;
        priority if (src_rem[STEP_OPEN])
        begin
            step[STEP_OPEN] = 1'b1;
            emit_byte       = flag_byte;
        end
        else if (src_rem[STEP_ESC])
        begin
            step[STEP_ESC] = 1'b1;
            emit_byte      = escape_byte;
        end
        else if (src_rem[STEP_DATA])
        begin
            step[STEP_DATA] = 1'b1;
            emit_byte       = src_data;
        end
        else
        begin
            step[STEP_CLOSE] = 1'b1;
            emit_byte        = flag_byte;
        end

        rem_after = src_rem & ~step;
        closing   = step[STEP_CLOSE];
        new_par   = (step[STEP_OPEN] ? 1'b0 : par_reg) ^ (^emit_byte);
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        par_next       = par_reg;
        m_tvalid_next  = m_tvalid_reg;
        if (fire)
        begin
            cur_valid_next = (rem_after != '0);
            par_next       = closing ? 1'b0 : new_par;
            m_tvalid_next  = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            par_reg       <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            par_reg       <= par_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rem_reg        <= rem_after;
            data_reg       <= src_data;
            out_byte_reg   <= emit_byte;
            out_last_reg   <= (rem_after == '0);
            out_closed_reg <= closing;
            out_par_reg    <= closing & new_par;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(OUT_DATA_W - BYTE_W - 1)'(0), out_par_reg, out_byte_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_closed_reg;

endmodule

[src/bsf_checker.sv]
// ----------------------------------------------------------------------------
// Byte stuffing framer checker
// Port-level properties of the framer's output stream.
// ----------------------------------------------------------------------------
module bsf_checker
    import bsf_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tlast,
    input logic [OUT_USER_W-1:0] m_tuser
);

    // A stalled beat stays offered with its data and user bits unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    // Parity is only reported alongside the closing flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> !m_tdata[BYTE_W])
        else $error("parity set on a beat that is not a closing flag");

    // The closing flag is always the final beat of its input byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("closing flag without tlast");

    // Padding bits above the parity are zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_DATA_W-1:BYTE_W+1] == '0)
        else $error("non-zero padding in output data");

endmodule

bind byte_stuff_framer_with_parity_core bsf_checker u_bsf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
